@@ rtl/arcr_pkg.sv @@
// ============================================================================
// arcr_pkg: shared types and constants of the ARC directory
// Codes for lists, sequencer states, request kinds and statistic counters.
// ============================================================================
package arcr_pkg;

   localparam int SIZE_W   = 11;   // list sizes, up to twice the capacity
   localparam int CAP_W    = 10;   // capacity and adaptive target
   localparam int CNT_W    = 32;
   localparam int CNT_NUM  = 7;
   localparam int SUM_W    = 12;   // sums of list sizes

   localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;

   localparam int CNT_REQ      = 0;
   localparam int CNT_HIT      = 1;
   localparam int CNT_WB_ADMIT = 2;
   localparam int CNT_WB_EVICT = 3;
   localparam int CNT_WT_OVH   = 4;
   localparam int CNT_WT_EVICT = 5;
   localparam int CNT_WB_RDHIT = 6;

   localparam logic [2:0] FOUND_NONE = 3'd0;

   typedef enum logic [1:0] {
      LIST_T1,
      LIST_T2,
      LIST_B1,
      LIST_B2
   } list_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_LIST,
      S_SRCH_CHK,
      S_CLASS,
      S_DIV_START,
      S_DIV_WAIT,
      S_DISP,
      S_UNL,
      S_UNL_B,
      S_POP_RD,
      S_POP_CHK,
      S_PUSH_A,
      S_PUSH_B,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      STEP_PRE,
      STEP_REPL,
      STEP_ADMIT,
      STEP_FINISH
   } step_type;

   typedef enum logic [2:0] {
      K_HIT,
      K_GB1,
      K_GB2,
      K_MISS_A,
      K_MISS_B,
      K_MISS_C,
      K_MISS_D
   } kind_type;

   // Field write enables of the entry memory.
   typedef struct packed {
      logic data;
      logic prev;
      logic next;
   } mem_wr_type;

endpackage

@@ rtl/arcr_entry_mem.sv @@
// ============================================================================
// arcr_entry_mem: directory entry memory
// One write port with per-field enables and one registered read port.
// ============================================================================
module arcr_entry_mem #(
   parameter int DEPTH = 1024,
   parameter int TAG_W = 32
) (
   input  logic                      clock,
   input  arcr_pkg::mem_wr_type      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [TAG_W-1:0]          wr_tag,
   input  logic                      wr_dirty,
   input  logic [$clog2(DEPTH)-1:0]  wr_prev,
   input  logic [$clog2(DEPTH)-1:0]  wr_next,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [TAG_W-1:0]          rd_tag,
   output logic                      rd_dirty,
   output logic [$clog2(DEPTH)-1:0]  rd_prev,
   output logic [$clog2(DEPTH)-1:0]  rd_next
);
   import arcr_pkg::*;

   localparam int SLOT_W = $clog2(DEPTH);

   logic [TAG_W-1:0]  tag_mem   [DEPTH];
   logic              dirty_mem [DEPTH];
   logic [SLOT_W-1:0] prev_mem  [DEPTH];
   logic [SLOT_W-1:0] next_mem  [DEPTH];

   logic [TAG_W-1:0]  rd_tag_ff;
   logic              rd_dirty_ff;
   logic [SLOT_W-1:0] rd_prev_ff;
   logic [SLOT_W-1:0] rd_next_ff;

   always_ff @(posedge clock) begin
      if (wr_en.data) begin
         tag_mem[wr_addr]   <= wr_tag;
         dirty_mem[wr_addr] <= wr_dirty;
      end
      if (wr_en.prev) begin
         prev_mem[wr_addr] <= wr_prev;
      end
      if (wr_en.next) begin
         next_mem[wr_addr] <= wr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_dirty_ff <= dirty_mem[rd_addr];
         rd_prev_ff  <= prev_mem[rd_addr];
         rd_next_ff  <= next_mem[rd_addr];
      end
   end

   assign rd_tag   = rd_tag_ff;
   assign rd_dirty = rd_dirty_ff;
   assign rd_prev  = rd_prev_ff;
   assign rd_next  = rd_next_ff;

endmodule

@@ rtl/arcr_div.sv @@
// ============================================================================
// arcr_div: serial restoring divider for ghost-list size ratios
// One quotient bit per cycle; done pulses when the quotient is ready.
// ============================================================================
module arcr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [arcr_pkg::SIZE_W-1:0] num,
   input  logic [arcr_pkg::SIZE_W-1:0] den,
   output logic                        done,
   output logic [arcr_pkg::SIZE_W-1:0] quo
);
   import arcr_pkg::*;

   localparam int STEP_W = $clog2(SIZE_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SIZE_W:0]   rem_ff, rem_in;
   logic [SIZE_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0] den_ff, den_in;
   logic [SIZE_W:0]   rem_sh;
   logic [SIZE_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff[SIZE_W-1:0], quo_ff[SIZE_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!diff[SIZE_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[SIZE_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[SIZE_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SIZE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ rtl/arc_cache_replacement_core.sv @@
// ============================================================================
// arc_cache_replacement_core: Adaptive Replacement Cache directory
// Keeps T1, T2, B1 and B2 as linked lists in an entry memory and returns
// hit, writeback, adaptive target and statistics for every request beat.
// ============================================================================
// The search walks up to four lists, one entry at a time (up to 2c entries); a ghost
// hit then runs the size-ratio divide, and the list updates follow through the entry
// memory. One request at a time: the next request beat is taken once the result is
// in the output register.
// Reset empties all lists and clears p and counters (no clearing pass).
module arc_cache_replacement_core #(
   parameter int MAX_PAGES = 512,
   parameter int PAGE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_page,
   input  logic        req_is_read,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [2:0]  rsp_found_list,
   output logic        rsp_writeback,
   output logic [31:0] rsp_writeback_page,
   output logic [9:0]  rsp_target_p,
   output logic [31:0] rsp_request_count,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_wb_admit_count,
   output logic [31:0] rsp_wb_evict_count,
   output logic [31:0] rsp_wt_overhead_count,
   output logic [31:0] rsp_wt_evict_count,
   output logic [31:0] rsp_wb_read_hit_count,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);
   import arcr_pkg::*;

   // The four lists together never hold more than twice the capacity, so the
   // entry memory has one slot per possible directory entry.
   localparam int DEPTH  = 2 * MAX_PAGES;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int FILL_W = SLOT_W + 1;

   typedef logic [SLOT_W-1:0] slot_type;

   // Sequencer state.
   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   kind_type  kind_ff, kind_in;
   list_type  srl_ff, srl_in;
   list_type  op_list_ff, op_list_in;
   list_type  dst_ff, dst_in;
   logic      repl_ff, repl_in;
   logic      free_v_ff, free_v_in;
   logic      pop_b2_ff, pop_b2_in;
   logic      wb_ff, wb_in;

   // Request and operand payload.
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 rd_ff, rd_in;
   logic [2:0]           found_ff, found_in;
   slot_type             found_slot_ff, found_slot_in;
   logic                 found_dirty_ff, found_dirty_in;
   slot_type             cur_ff, cur_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   slot_type             op_slot_ff, op_slot_in;
   slot_type             op_prev_ff, op_prev_in;
   slot_type             op_next_ff, op_next_in;
   logic [PAGE_BITS-1:0] op_tag_ff, op_tag_in;
   logic                 op_dirty_ff, op_dirty_in;
   slot_type             free_slot_ff, free_slot_in;
   logic [PAGE_BITS-1:0] wb_page_ff, wb_page_in;

   // List directory and adaptive state.
   slot_type          head_ff [4];
   slot_type          head_in [4];
   slot_type          tail_ff [4];
   slot_type          tail_in [4];
   logic [SIZE_W-1:0] size_ff [4];
   logic [SIZE_W-1:0] size_in [4];
   logic [CAP_W-1:0]  p_ff, p_in;
   logic [CAP_W-1:0]  cp_ff, cp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  cnt_ff [CNT_NUM];
   logic [CNT_W-1:0]  cnt_in [CNT_NUM];
   logic              cnt_inc [CNT_NUM];

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [2:0]       rsp_found_ff, rsp_found_in;
   logic             rsp_wb_ff, rsp_wb_in;
   logic [31:0]      rsp_wb_page_ff, rsp_wb_page_in;
   logic [CAP_W-1:0] rsp_p_ff, rsp_p_in;
   logic [CNT_W-1:0] rsp_cnt_ff [CNT_NUM];
   logic [CNT_W-1:0] rsp_cnt_in [CNT_NUM];

   // Entry memory and divider connections.
   mem_wr_type           mem_wr;
   slot_type             mem_wr_addr;
   slot_type             mem_wr_prev;
   slot_type             mem_wr_next;
   logic                 mem_rd_en;
   slot_type             mem_rd_addr;
   logic [PAGE_BITS-1:0] mem_rd_tag;
   logic                 mem_rd_dirty;
   slot_type             mem_rd_prev;
   slot_type             mem_rd_next;
   logic                 div_start;
   logic [SIZE_W-1:0]    div_num;
   logic [SIZE_W-1:0]    div_den;
   logic                 div_done;
   logic [SIZE_W-1:0]    div_quo;

   // Derived values.
   logic [CAP_W-1:0]  cap_c;
   logic [SUM_W-1:0]  t1b1;
   logic [SUM_W-1:0]  total;
   logic [SUM_W-1:0]  cap_ext;
   logic [SIZE_W-1:0] div_d;
   logic [SUM_W-1:0]  p_up;
   logic              repl_any;
   list_type          repl_src;
   list_type          repl_dst;
   logic              take_t1;
   logic              is_head;
   logic              is_tail;
   logic              is_hit;

   arcr_entry_mem #(
      .DEPTH (DEPTH),
      .TAG_W (PAGE_BITS)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_wr),
      .wr_addr  (mem_wr_addr),
      .wr_tag   (op_tag_ff),
      .wr_dirty (op_dirty_ff),
      .wr_prev  (mem_wr_prev),
      .wr_next  (mem_wr_next),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_tag   (mem_rd_tag),
      .rd_dirty (mem_rd_dirty),
      .rd_prev  (mem_rd_prev),
      .rd_next  (mem_rd_next)
   );

   arcr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Effective capacity: the written value clamped to 1..MAX_PAGES.
   always_comb begin
      if (cp_ff == '0) begin
         cap_c = CAP_W'(1);
      end else if (32'(cp_ff) > 32'(MAX_PAGES)) begin
         cap_c = CAP_W'(MAX_PAGES);
      end else begin
         cap_c = cp_ff;
      end
   end

   assign cap_ext = SUM_W'(cap_c);
   assign t1b1    = SUM_W'(size_ff[LIST_T1]) + SUM_W'(size_ff[LIST_B1]);
   assign total   = t1b1 + SUM_W'(size_ff[LIST_T2]) + SUM_W'(size_ff[LIST_B2]);

   // A hit in B1 divides |B2| by |B1|, a hit in B2 the other way round.
   assign div_num = (kind_ff == K_GB1) ? size_ff[LIST_B2] : size_ff[LIST_B1];
   assign div_den = (kind_ff == K_GB1) ? size_ff[LIST_B1] : size_ff[LIST_B2];
   assign div_d   = (div_quo == '0) ? SIZE_W'(1) : div_quo;
   assign p_up    = SUM_W'(p_ff) + SUM_W'(div_d);

   // REPLACE picks its victim list from the sizes as they stand at that step.
   // T1 wins when it exceeds p, or equals p on a B2 ghost hit; otherwise T2,
   // and T1 again as the fallback when T2 is empty.
   assign take_t1 = (size_ff[LIST_T1] != '0) &&
                    ((size_ff[LIST_T1] > SIZE_W'(p_ff)) ||
                     ((kind_ff == K_GB2) && (size_ff[LIST_T1] == SIZE_W'(p_ff))));

   always_comb begin
      repl_any = 1'b1;
      repl_src = LIST_T1;
      repl_dst = LIST_B1;
      if (take_t1) begin
         repl_src = LIST_T1;
         repl_dst = LIST_B1;
      end else if (size_ff[LIST_T2] != '0) begin
         repl_src = LIST_T2;
         repl_dst = LIST_B2;
      end else if (size_ff[LIST_T1] != '0) begin
         repl_src = LIST_T1;
         repl_dst = LIST_B1;
      end else begin
         repl_any = 1'b0;
      end
   end

   assign is_head = (op_slot_ff == head_ff[op_list_ff]);
   assign is_tail = (op_slot_ff == tail_ff[op_list_ff]);
   assign is_hit  = (kind_ff == K_HIT);

   // Statistic increments for the request being finished.
   always_comb begin
      cnt_inc[CNT_REQ]      = 1'b1;
      cnt_inc[CNT_HIT]      = is_hit;
      cnt_inc[CNT_WB_ADMIT] = !is_hit && rd_ff;
      cnt_inc[CNT_WB_EVICT] = wb_ff;
      cnt_inc[CNT_WT_OVH]   = !(is_hit && rd_ff);
      cnt_inc[CNT_WT_EVICT] = !rd_ff;
      cnt_inc[CNT_WB_RDHIT] = is_hit && rd_ff;
   end

   // Request sequencer. Every request first walks the lists to find the page,
   // then runs a short plan of list primitives (unlink, pop, push) through the
   // entry memory ports: the first step removes the found entry or the entry
   // that case IV discards, the second runs REPLACE, the third admits the page.
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      kind_in        = kind_ff;
      srl_in         = srl_ff;
      op_list_in     = op_list_ff;
      dst_in         = dst_ff;
      repl_in        = repl_ff;
      free_v_in      = free_v_ff;
      pop_b2_in      = pop_b2_ff;
      wb_in          = wb_ff;
      page_in        = page_ff;
      rd_in          = rd_ff;
      found_in       = found_ff;
      found_slot_in  = found_slot_ff;
      found_dirty_in = found_dirty_ff;
      cur_in         = cur_ff;
      rem_in         = rem_ff;
      op_slot_in     = op_slot_ff;
      op_prev_in     = op_prev_ff;
      op_next_in     = op_next_ff;
      op_tag_in      = op_tag_ff;
      op_dirty_in    = op_dirty_ff;
      free_slot_in   = free_slot_ff;
      wb_page_in     = wb_page_ff;
      p_in           = p_ff;
      cp_in          = cp_ff;
      fill_in        = fill_ff;
      for (int i = 0; i < 4; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         size_in[i] = size_ff[i];
      end
      for (int i = 0; i < CNT_NUM; i++) begin
         cnt_in[i]     = cnt_ff[i];
         rsp_cnt_in[i] = rsp_cnt_ff[i];
      end
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_hit_in     = rsp_hit_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_wb_in      = rsp_wb_ff;
      rsp_wb_page_in = rsp_wb_page_ff;
      rsp_p_in       = rsp_p_ff;
      mem_wr         = '0;
      mem_wr_addr    = '0;
      mem_wr_prev    = '0;
      mem_wr_next    = '0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = '0;
      div_start      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               page_in    = PAGE_BITS'(req_page);
               rd_in      = req_is_read;
               srl_in     = LIST_T1;
               found_in   = FOUND_NONE;
               wb_in      = 1'b0;
               wb_page_in = '0;
               free_v_in  = 1'b0;
               repl_in    = 1'b0;
               state_in   = S_SRCH_LIST;
            end
         end

         S_SRCH_LIST: begin
            if (size_ff[srl_ff] != '0) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = head_ff[srl_ff];
               cur_in      = head_ff[srl_ff];
               rem_in      = size_ff[srl_ff];
               state_in    = S_SRCH_CHK;
            end else if (srl_ff == LIST_B2) begin
               state_in = S_CLASS;
            end else begin
               srl_in = list_type'(srl_ff + 2'd1);
            end
         end

         S_SRCH_CHK: begin
            // The entry read last cycle is compared while its successor is read.
            if (mem_rd_tag == page_ff) begin
               found_in       = 3'({1'b0, srl_ff}) + 3'd1;
               found_slot_in  = cur_ff;
               found_dirty_in = mem_rd_dirty;
               op_prev_in     = mem_rd_prev;
               op_next_in     = mem_rd_next;
               step_in        = STEP_PRE;
               unique case (srl_ff)
                  LIST_T1, LIST_T2: begin
                     kind_in  = K_HIT;
                     state_in = S_DISP;
                  end
                  LIST_B1: begin
                     kind_in  = K_GB1;
                     state_in = S_DIV_START;
                  end
                  LIST_B2: begin
                     kind_in  = K_GB2;
                     state_in = S_DIV_START;
                  end
               endcase
            end else if (rem_ff == SIZE_W'(1)) begin
               if (srl_ff == LIST_B2) begin
                  state_in = S_CLASS;
               end else begin
                  srl_in   = list_type'(srl_ff + 2'd1);
                  state_in = S_SRCH_LIST;
               end
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mem_rd_next;
               cur_in      = mem_rd_next;
               rem_in      = rem_ff - SIZE_W'(1);
            end
         end

         S_CLASS: begin
            // Full miss: the case IV split on |T1|+|B1| and the total size.
            pop_b2_in = (total >= (cap_ext << 1));
            if (t1b1 == cap_ext) begin
               kind_in = (SUM_W'(size_ff[LIST_T1]) < cap_ext) ? K_MISS_A : K_MISS_B;
            end else if ((t1b1 < cap_ext) && (total >= cap_ext)) begin
               kind_in = K_MISS_C;
            end else begin
               kind_in = K_MISS_D;
            end
            step_in  = STEP_PRE;
            state_in = S_DISP;
         end

         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               if (kind_ff == K_GB1) begin
                  p_in = (p_up > cap_ext) ? cap_c : CAP_W'(p_up);
               end else if (SUM_W'(p_ff) > SUM_W'(div_d)) begin
                  p_in = CAP_W'(SUM_W'(p_ff) - SUM_W'(div_d));
               end else begin
                  p_in = '0;
               end
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            unique case (step_ff)
               STEP_PRE: begin
                  step_in = STEP_REPL;
                  repl_in = 1'b0;
                  unique case (kind_ff)
                     K_HIT, K_GB1, K_GB2: begin
                        op_list_in = srl_ff;
                        op_slot_in = found_slot_ff;
                        state_in   = S_UNL;
                     end
                     K_MISS_A: begin
                        op_list_in = LIST_B1;
                        state_in   = S_POP_RD;
                     end
                     K_MISS_B: begin
                        op_list_in = LIST_T1;
                        state_in   = S_POP_RD;
                     end
                     K_MISS_C: begin
                        if (pop_b2_ff && (size_ff[LIST_B2] != '0)) begin
                           op_list_in = LIST_B2;
                           state_in   = S_POP_RD;
                        end
                     end
                     K_MISS_D: begin
                     end
                     default: begin
                     end
                  endcase
               end
               STEP_REPL: begin
                  step_in = STEP_ADMIT;
                  if (((kind_ff == K_GB1) || (kind_ff == K_GB2) ||
                       (kind_ff == K_MISS_A) || (kind_ff == K_MISS_C)) && repl_any) begin
                     op_list_in = repl_src;
                     dst_in     = repl_dst;
                     repl_in    = 1'b1;
                     state_in   = S_POP_RD;
                  end
               end
               STEP_ADMIT: begin
                  step_in   = STEP_FINISH;
                  op_tag_in = page_ff;
                  state_in  = S_PUSH_A;
                  if (is_hit) begin
                     op_list_in  = LIST_T2;
                     op_slot_in  = found_slot_ff;
                     op_dirty_in = rd_ff ? found_dirty_ff : 1'b1;
                  end else if ((kind_ff == K_GB1) || (kind_ff == K_GB2)) begin
                     op_list_in  = LIST_T2;
                     op_slot_in  = found_slot_ff;
                     op_dirty_in = !rd_ff;
                  end else begin
                     // A slot discarded by this request is reused first.
                     op_list_in  = LIST_T1;
                     op_dirty_in = !rd_ff;
                     if (free_v_ff) begin
                        op_slot_in = free_slot_ff;
                     end else begin
                        op_slot_in = fill_ff[SLOT_W-1:0];
                        fill_in    = fill_ff + FILL_W'(1);
                     end
                  end
               end
               STEP_FINISH: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_UNL: begin
            // Only links between interior neighbors are written; the prev of
            // a head and the next of a tail are never read.
            size_in[op_list_ff] = size_ff[op_list_ff] - SIZE_W'(1);
            state_in            = S_DISP;
            if (is_head && is_tail) begin
            end else if (is_head) begin
               head_in[op_list_ff] = op_next_ff;
            end else if (is_tail) begin
               tail_in[op_list_ff] = op_prev_ff;
            end else begin
               mem_wr.next = 1'b1;
               mem_wr_addr = op_prev_ff;
               mem_wr_next = op_next_ff;
               state_in    = S_UNL_B;
            end
         end

         S_UNL_B: begin
            mem_wr.prev = 1'b1;
            mem_wr_addr = op_next_ff;
            mem_wr_prev = op_prev_ff;
            state_in    = S_DISP;
         end

         S_POP_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = head_ff[op_list_ff];
            state_in    = S_POP_CHK;
         end

         S_POP_CHK: begin
            size_in[op_list_ff] = size_ff[op_list_ff] - SIZE_W'(1);
            if (size_ff[op_list_ff] != SIZE_W'(1)) begin
               head_in[op_list_ff] = mem_rd_next;
            end
            if (((op_list_ff == LIST_T1) || (op_list_ff == LIST_T2)) && mem_rd_dirty) begin
               wb_in      = 1'b1;
               wb_page_in = mem_rd_tag;
            end
            if (repl_ff) begin
               // REPLACE: the victim keeps its slot and moves to a ghost list.
               op_list_in  = dst_ff;
               op_slot_in  = head_ff[op_list_ff];
               op_tag_in   = mem_rd_tag;
               op_dirty_in = mem_rd_dirty;
               repl_in     = 1'b0;
               state_in    = S_PUSH_A;
            end else begin
               free_slot_in = head_ff[op_list_ff];
               free_v_in    = 1'b1;
               state_in     = S_DISP;
            end
         end

         S_PUSH_A: begin
            if (size_ff[op_list_ff] == '0) begin
               head_in[op_list_ff] = op_slot_ff;
            end else begin
               mem_wr.next = 1'b1;
               mem_wr_addr = tail_ff[op_list_ff];
               mem_wr_next = op_slot_ff;
               op_prev_in  = tail_ff[op_list_ff];
            end
            state_in = S_PUSH_B;
         end

         S_PUSH_B: begin
            mem_wr.data              = 1'b1;
            mem_wr.prev              = 1'b1;
            mem_wr_addr              = op_slot_ff;
            mem_wr_prev              = op_prev_ff;
            tail_in[op_list_ff]      = op_slot_ff;
            size_in[op_list_ff]      = size_ff[op_list_ff] + SIZE_W'(1);
            state_in                 = S_DISP;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               for (int i = 0; i < CNT_NUM; i++) begin
                  if (cnt_inc[i] && (cnt_ff[i] != '1)) begin
                     cnt_in[i] = cnt_ff[i] + CNT_W'(1);
                  end
                  rsp_cnt_in[i] = cnt_in[i];
               end
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = is_hit;
               rsp_found_in   = found_ff;
               rsp_wb_in      = wb_ff;
               rsp_wb_page_in = 32'(wb_page_ff);
               rsp_p_in       = p_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A capacity write empties every list and clears p; the statistics stay.
      if (csr_wr_en) begin
         cp_in   = csr_wr_data;
         p_in    = '0;
         fill_in = '0;
         for (int i = 0; i < 4; i++) begin
            size_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         p_ff         <= '0;
         cp_ff        <= CAP_RESET;
         fill_ff      <= '0;
         for (int i = 0; i < 4; i++) begin
            size_ff[i] <= '0;
         end
         for (int i = 0; i < CNT_NUM; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p_ff         <= p_in;
         cp_ff        <= cp_in;
         fill_ff      <= fill_in;
         for (int i = 0; i < 4; i++) begin
            size_ff[i] <= size_in[i];
         end
         for (int i = 0; i < CNT_NUM; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      kind_ff        <= kind_in;
      srl_ff         <= srl_in;
      op_list_ff     <= op_list_in;
      dst_ff         <= dst_in;
      repl_ff        <= repl_in;
      free_v_ff      <= free_v_in;
      pop_b2_ff      <= pop_b2_in;
      wb_ff          <= wb_in;
      page_ff        <= page_in;
      rd_ff          <= rd_in;
      found_ff       <= found_in;
      found_slot_ff  <= found_slot_in;
      found_dirty_ff <= found_dirty_in;
      cur_ff         <= cur_in;
      rem_ff         <= rem_in;
      op_slot_ff     <= op_slot_in;
      op_prev_ff     <= op_prev_in;
      op_next_ff     <= op_next_in;
      op_tag_ff      <= op_tag_in;
      op_dirty_ff    <= op_dirty_in;
      free_slot_ff   <= free_slot_in;
      wb_page_ff     <= wb_page_in;
      for (int i = 0; i < 4; i++) begin
         head_ff[i] <= head_in[i];
         tail_ff[i] <= tail_in[i];
      end
      rsp_hit_ff     <= rsp_hit_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_wb_ff      <= rsp_wb_in;
      rsp_wb_page_ff <= rsp_wb_page_in;
      rsp_p_ff       <= rsp_p_in;
      for (int i = 0; i < CNT_NUM; i++) begin
         rsp_cnt_ff[i] <= rsp_cnt_in[i];
      end
   end

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_found_list        = rsp_found_ff;
   assign rsp_writeback         = rsp_wb_ff;
   assign rsp_writeback_page    = rsp_wb_page_ff;
   assign rsp_target_p          = rsp_p_ff;
   assign rsp_request_count     = rsp_cnt_ff[CNT_REQ];
   assign rsp_hit_count         = rsp_cnt_ff[CNT_HIT];
   assign rsp_wb_admit_count    = rsp_cnt_ff[CNT_WB_ADMIT];
   assign rsp_wb_evict_count    = rsp_cnt_ff[CNT_WB_EVICT];
   assign rsp_wt_overhead_count = rsp_cnt_ff[CNT_WT_OVH];
   assign rsp_wt_evict_count    = rsp_cnt_ff[CNT_WT_EVICT];
   assign rsp_wb_read_hit_count = rsp_cnt_ff[CNT_WB_RDHIT];

   // Slot allocation never runs past the entry memory.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("slot fill count beyond entry memory depth");

   // The adaptive target stays within the effective capacity.
   a_p_bound : assert property (@(posedge clock) disable iff (reset)
      p_ff <= cap_c)
      else $error("adaptive target above capacity");

   // Resident hits never outnumber requests.
   a_hit_le_req : assert property (@(posedge clock) disable iff (reset)
      cnt_ff[CNT_HIT] <= cnt_ff[CNT_REQ])
      else $error("hit counter above request counter");

   // A result beat without writeback carries page zero.
   a_wb_page_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_wb_ff) |-> (rsp_wb_page_ff == '0))
      else $error("writeback page set without writeback");

endmodule

@@ verif/arc_cache_replacement_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// arc_cache_replacement_checker: ARC directory result predictor and checker
// Watches accepted request and response beats, runs a list-based ARC model
// of the directory and compares every response beat field by field.
// ============================================================================
module arc_cache_replacement_checker #(
   parameter int MAX_PAGES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_page,
   input  logic        req_is_read,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_hit,
   input  logic [2:0]  rsp_found_list,
   input  logic        rsp_writeback,
   input  logic [31:0] rsp_writeback_page,
   input  logic [9:0]  rsp_target_p,
   input  logic [31:0] rsp_request_count,
   input  logic [31:0] rsp_hit_count,
   input  logic [31:0] rsp_wb_admit_count,
   input  logic [31:0] rsp_wb_evict_count,
   input  logic [31:0] rsp_wt_overhead_count,
   input  logic [31:0] rsp_wt_evict_count,
   input  logic [31:0] rsp_wb_read_hit_count,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data,
   output int          fail_count,
   output int          pending_count,
   output int          ghost_hits,
   output int          dirty_evicts
);
   import arcr_pkg::*;

   localparam logic [2:0] FOUND_T1 = 3'd1;
   localparam logic [2:0] FOUND_T2 = 3'd2;
   localparam logic [2:0] FOUND_B1 = 3'd3;
   localparam logic [2:0] FOUND_B2 = 3'd4;

   typedef struct packed {
      logic        hit;
      logic [2:0]  found;
      logic        wb;
      logic [31:0] wb_page;
      logic [9:0]  p;
      logic [31:0] c_req, c_hit, c_wb_admit, c_wb_evict, c_wt_ovh, c_wt_evict, c_rdhit;
   } arc_result_t;

   typedef struct packed {
      logic [31:0] page;
      logic        dirty;
   } dir_entry_t;

   dir_entry_t  dir_list [4][$];
   logic [31:0] stat [CNT_NUM];
   int unsigned target_p;
   logic [9:0]  cap_reg;
   logic        evict_flag;
   logic [31:0] evict_page;
   arc_result_t expected_results [$];

   assign pending_count = expected_results.size();

   function automatic int unsigned capacity();
      int unsigned c;
      c = cap_reg;
      if (c < 1) c = 1;
      if (c > MAX_PAGES) c = MAX_PAGES;
      return c;
   endfunction

   function automatic void bump(int k);
      if (stat[k] != 32'hFFFF_FFFF) stat[k] = stat[k] + 1;
   endfunction

   function automatic void empty_lists();
      for (int l = 0; l < 4; l++) dir_list[l].delete();
      target_p = 0;
   endfunction

   function automatic void note_evict(logic [31:0] pg);
      evict_flag = 1'b1;
      evict_page = pg;
      bump(CNT_WB_EVICT);
      dirty_evicts++;
   endfunction

   // Moves the LRU resident page of the chosen list to its ghost list.
   function automatic void replace_lru(bit from_b2);
      int unsigned s1;
      int src, dst;
      dir_entry_t e;
      s1 = dir_list[LIST_T1].size();
      if (s1 != 0 && (s1 > target_p || (from_b2 && s1 == target_p))) begin
         src = LIST_T1; dst = LIST_B1;
      end else if (dir_list[LIST_T2].size() != 0) begin
         src = LIST_T2; dst = LIST_B2;
      end else if (s1 != 0) begin
         src = LIST_T1; dst = LIST_B1;
      end else begin
         return;
      end
      e = dir_list[src].pop_front();
      dir_list[dst].push_back(e);
      if (e.dirty) note_evict(e.page);
   endfunction

   function automatic void fill_counts(bit rd);
      if (rd) bump(CNT_WB_ADMIT);
      else bump(CNT_WT_EVICT);
      bump(CNT_WT_OVH);
   endfunction

   function automatic arc_result_t predict_access(logic [31:0] page, bit rd);
      arc_result_t r;
      int found, pos;
      int unsigned c, d, t1b1, total;
      dir_entry_t e;
      c = capacity();
      found = 0;
      pos = -1;
      evict_flag = 1'b0;
      evict_page = '0;
      bump(CNT_REQ);
      for (int l = 0; l < 4 && found == 0; l++)
         foreach (dir_list[l][i])
            if (found == 0 && dir_list[l][i].page == page) begin
               found = l + 1;
               pos = i;
            end
      if (found == 1 || found == 2) begin
         e = dir_list[found-1][pos];
         bump(CNT_HIT);
         if (rd) bump(CNT_WB_RDHIT);
         else begin
            bump(CNT_WT_OVH);
            bump(CNT_WT_EVICT);
         end
         dir_list[found-1].delete(pos);
         dir_list[LIST_T2].push_back('{page, rd ? e.dirty : 1'b1});
      end else if (found == 3 || found == 4) begin
         ghost_hits++;
         if (found == 3) begin
            d = dir_list[LIST_B2].size() / dir_list[LIST_B1].size();
            if (d < 1) d = 1;
            target_p = (target_p + d > c) ? c : target_p + d;
            dir_list[LIST_B1].delete(pos);
            replace_lru(1'b0);
         end else begin
            d = dir_list[LIST_B1].size() / dir_list[LIST_B2].size();
            if (d < 1) d = 1;
            target_p = (target_p > d) ? target_p - d : 0;
            dir_list[LIST_B2].delete(pos);
            replace_lru(1'b1);
         end
         fill_counts(rd);
         dir_list[LIST_T2].push_back('{page, !rd});
      end else begin
         t1b1 = dir_list[LIST_T1].size() + dir_list[LIST_B1].size();
         total = t1b1 + dir_list[LIST_T2].size() + dir_list[LIST_B2].size();
         if (t1b1 == c) begin
            if (dir_list[LIST_T1].size() < c) begin
               if (dir_list[LIST_B1].size() != 0) void'(dir_list[LIST_B1].pop_front());
               replace_lru(1'b0);
            end else if (dir_list[LIST_T1].size() != 0) begin
               e = dir_list[LIST_T1].pop_front();
               if (e.dirty) note_evict(e.page);
            end
         end else if (t1b1 < c && total >= c) begin
            if (total >= 2 * c && dir_list[LIST_B2].size() != 0)
               void'(dir_list[LIST_B2].pop_front());
            replace_lru(1'b0);
         end
         fill_counts(rd);
         dir_list[LIST_T1].push_back('{page, !rd});
      end
      r.hit = (found == 1 || found == 2);
      r.found = found[2:0];
      r.wb = evict_flag;
      r.wb_page = evict_page;
      r.p = target_p[9:0];
      r.c_req = stat[CNT_REQ];
      r.c_hit = stat[CNT_HIT];
      r.c_wb_admit = stat[CNT_WB_ADMIT];
      r.c_wb_evict = stat[CNT_WB_EVICT];
      r.c_wt_ovh = stat[CNT_WT_OVH];
      r.c_wt_evict = stat[CNT_WT_EVICT];
      r.c_rdhit = stat[CNT_WB_RDHIT];
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      arc_result_t e;
      if (reset) begin
         empty_lists();
         for (int k = 0; k < CNT_NUM; k++) stat[k] = '0;
         cap_reg = CAP_RESET;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            cap_reg = csr_wr_data;
            empty_lists();
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response beat with no request pending", $time);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               compare_field("hit", e.hit, rsp_hit);
               compare_field("found_list", e.found, rsp_found_list);
               compare_field("writeback", e.wb, rsp_writeback);
               compare_field("writeback_page", e.wb_page, rsp_writeback_page);
               compare_field("target_p", e.p, rsp_target_p);
               compare_field("request_count", e.c_req, rsp_request_count);
               compare_field("hit_count", e.c_hit, rsp_hit_count);
               compare_field("wb_admit_count", e.c_wb_admit, rsp_wb_admit_count);
               compare_field("wb_evict_count", e.c_wb_evict, rsp_wb_evict_count);
               compare_field("wt_overhead_count", e.c_wt_ovh, rsp_wt_overhead_count);
               compare_field("wt_evict_count", e.c_wt_evict, rsp_wt_evict_count);
               compare_field("wb_read_hit_count", e.c_rdhit, rsp_wb_read_hit_count);
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_access(req_page, req_is_read));
      end
   end

   initial begin
      fail_count = 0;
      ghost_hits = 0;
      dirty_evicts = 0;
   end
endmodule

@@ verif/arc_cache_replacement_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// arc_cache_replacement_core_tb: stimulus and verdict for the ARC directory
// Drives page requests in phases of different capacities, with random idle
// and stall cycles on both channels, and takes the failure count from the
// checker.
// ============================================================================
module arc_cache_replacement_core_tb;
   import arcr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_page;
   logic        req_is_read;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_hit;
   logic [2:0]  rsp_found_list;
   logic        rsp_writeback;
   logic [31:0] rsp_writeback_page;
   logic [9:0]  rsp_target_p;
   logic [31:0] rsp_request_count, rsp_hit_count, rsp_wb_admit_count;
   logic [31:0] rsp_wb_evict_count, rsp_wt_overhead_count, rsp_wt_evict_count;
   logic [31:0] rsp_wb_read_hit_count;
   logic        csr_wr_en;
   logic [9:0]  csr_wr_data;
   int          fail_count, pending_count, ghost_hits, dirty_evicts;

   // The idle knobs: percent of cycles that each side sits out.
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_off;
   int          beats_sent;

   arc_cache_replacement_core i_dut (.*);

   arc_cache_replacement_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: stalls at random, and once holds off for a long stretch so
   // that the block fills its output register and stalls the request side.
   initial begin
      rsp_stall = 1'b1;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            for (int i = 0; i < 400; i++) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offers one request beat and holds it until the block accepts it. The
   // sender may idle first, which leaves gaps in front of the beat.
   task automatic send_request(logic [31:0] page, logic rd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_page    <= page;
      req_is_read <= rd;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // Lets the block drain all pending responses before a capacity write.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_capacity(logic [9:0] cap);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // A random run on a small working set so that hits, ghost hits and
   // evictions all come up; a few beats are full-width noise pages.
   task automatic random_phase(int count, int span);
      logic [31:0] pg;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(19) == 0) pg = $urandom;
         else if ($urandom_range(3) == 0) pg = 32'hFFFF_FF00 + $urandom_range(span);
         else pg = $urandom_range(span);
         send_request(pg, $urandom_range(1));
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_page    = '0;
      req_is_read = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 33;
      recv_idle_pct = 33;
      hold_off    = 1'b0;
      beats_sent  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset capacity: page extremes, read and write
      // hits in T1, a read hit in T2, a write after a read.
      send_request(32'h0000_0000, 1'b1);
      send_request(32'hFFFF_FFFF, 1'b0);
      send_request(32'h0000_0000, 1'b0);
      send_request(32'hFFFF_FFFF, 1'b1);
      send_request(32'h0000_0000, 1'b1);
      send_request(32'hAAAA_5555, 1'b1);

      // Capacity of one: every miss after the first evicts a page, and the
      // replace step moves a T2 page to B2.
      write_capacity(10'd1);
      send_request(32'd10, 1'b0);
      send_request(32'd11, 1'b1);
      send_request(32'd10, 1'b1);
      send_request(32'd10, 1'b0);
      send_request(32'd12, 1'b0);
      send_request(32'd11, 1'b0);
      send_request(32'd12, 1'b1);

      // Capacity zero is clamped to one; a write also empties the lists.
      write_capacity(10'd0);
      send_request(32'd10, 1'b1);
      send_request(32'd20, 1'b0);
      send_request(32'd20, 1'b1);

      // Out-of-range capacity is clamped to the maximum.
      write_capacity(10'h3FF);
      send_request(32'h8000_0000, 1'b0);
      send_request(32'h7FFF_FFFF, 1'b1);

      // Random phases at several capacities. The first small one holds a
      // stretch with no idling at all and the long receiver hold-off.
      write_capacity(10'd4);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off = 1'b1;
      random_phase(150, 12);
      send_idle_pct = 33;
      recv_idle_pct = 33;
      random_phase(250, 12);
      write_capacity(10'd2);
      random_phase(250, 6);
      write_capacity(10'd16);
      random_phase(400, 48);
      write_capacity(10'd7);
      random_phase(300, 20);
      write_capacity(10'd512);
      random_phase(200, 40);
      wait_idle();

      $display("Covered %0d request beats over capacities 0..1023 with %0d ghost hits",
               beats_sent, ghost_hits);
      $display("and %0d dirty evictions, with random idling and a long receiver hold-off.",
               dirty_evicts);
      if (fail_count == 0) begin
         $display("arc_cache_replacement_core: match");
      end else begin
         $display("arc_cache_replacement_core: mismatch");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("arc_cache_replacement_core: mismatch");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/arcr_pkg.sv
rtl/arcr_entry_mem.sv
rtl/arcr_div.sv
rtl/arc_cache_replacement_core.sv
verif/arc_cache_replacement_checker.sv
verif/arc_cache_replacement_core_tb.sv
